@@ hdl/rfq_pkg.sv @@
// ----------------------------------------------------------------------------
// Request queue package
// Entry layout, cell control, field widths, and mode, policy and register codes.
// ----------------------------------------------------------------------------
package rfq_pkg;

  localparam int unsigned DefaultDepth = 16;

  localparam int unsigned IdW     = 32;
  localparam int unsigned SecW    = 32;
  localparam int unsigned NsecW   = 30;
  localparam int unsigned ImageW  = 32;
  localparam int unsigned OpW     = 4;
  localparam int unsigned OccW    = 5;
  localparam int unsigned CapW    = 5;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 5;

  localparam logic [CfgIdxW-1:0] CFG_POLICY   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_CAPACITY = 1'b1;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_SJN  = 1'b1;

  localparam logic [CapW-1:0] CapacityReset = CapW'(16);

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [SecW-1:0]   sec;
    logic [NsecW-1:0]  nsec;
    logic [ImageW-1:0] image;
    logic [OpW-1:0]    op;
    logic              ow;
  } entry_t;

  typedef struct packed {
    logic enq;
    logic deq;
    logic sjn;
  } ctrl_t;

endpackage

@@ hdl/fifo_or_shortest_first_request_queue.sv @@
// ----------------------------------------------------------------------------
// Bounded request queue, first-in-first-out or shortest job next
// Each result is registered and appears in the cycle after its request transfer.
// Throughput: one request per cycle; the insert compare and shift across the
// cell row are combinational, and a held result stalls input.
// Reset: queue empty, policy first-in-first-out, capacity 16.
// ----------------------------------------------------------------------------
module fifo_or_shortest_first_request_queue #(
  parameter int unsigned QUEUE_DEPTH = rfq_pkg::DefaultDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [rfq_pkg::IdW-1:0]      request_id_i,
  input  logic [rfq_pkg::SecW-1:0]     length_sec_i,
  input  logic [rfq_pkg::NsecW-1:0]    length_nsec_i,
  input  logic [rfq_pkg::ImageW-1:0]   image_id_i,
  input  logic [rfq_pkg::OpW-1:0]      operation_i,
  input  logic                         overwrite_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         rejected_o,
  output logic                         head_valid_o,
  output logic [rfq_pkg::IdW-1:0]      out_request_id_o,
  output logic [rfq_pkg::SecW-1:0]     out_length_sec_o,
  output logic [rfq_pkg::NsecW-1:0]    out_length_nsec_o,
  output logic [rfq_pkg::ImageW-1:0]   out_image_id_o,
  output logic [rfq_pkg::OpW-1:0]      out_operation_o,
  output logic                         out_overwrite_o,
  output logic [rfq_pkg::OccW-1:0]     occupancy_o,
  input  logic                         cfg_we_i,
  input  logic [rfq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rfq_pkg::CfgW-1:0]     cfg_data_i
);
  import rfq_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;

  logic            policy_q;
  logic [CapW-1:0] capacity_q;
  logic [CntW-1:0] count_q, count_d;

  logic            out_valid_q;
  logic            rejected_q, rejected_d;
  logic            head_valid_q, head_valid_d;
  entry_t          out_entry_q, out_entry_d;
  logic [OccW-1:0] occ_q, occ_d;

  entry_t                 new_entry;
  ctrl_t                  ctrl;
  entry_t                 cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [QUEUE_DEPTH-1:0] stop_vec;
  logic [QUEUE_DEPTH-1:0] sfx_vec;

  logic [CmpW-1:0] cap_ext, cap_eff, cnt_ext;
  logic            full, xfer, take_head;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign xfer       = in_valid_i && in_ready_o;

  assign cap_ext = CmpW'(capacity_q);
  assign cnt_ext = CmpW'(count_q);
  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = CmpW'(1);
    end else if (cap_ext > CmpW'(QUEUE_DEPTH)) begin
      cap_eff = CmpW'(QUEUE_DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end
  assign full = cnt_ext >= cap_eff;

  assign new_entry = '{id: request_id_i, sec: length_sec_i, nsec: length_nsec_i,
                       image: image_id_i, op: operation_i, ow: overwrite_i};

  assign take_head = xfer && (mode_i == MODE_DEQ) && cell_valid[0];
  assign ctrl.enq  = xfer && (mode_i == MODE_ENQ) && !full;
  assign ctrl.deq  = xfer && (mode_i == MODE_DEQ);
  assign ctrl.sjn  = (policy_q == POLICY_SJN);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_sfx
    assign sfx_vec[i] = |(stop_vec >> i);
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_v, left_s, right_v;
    if (i == 0) begin : g_head
      assign left_e = new_entry;
      assign left_v = 1'b0;
      assign left_s = 1'b1;
    end else begin : g_mid_l
      assign left_e = cell_entry[i-1];
      assign left_v = cell_valid[i-1];
      assign left_s = stop_vec[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = new_entry;
      assign right_v = 1'b0;
    end else begin : g_mid_r
      assign right_e = cell_entry[i+1];
      assign right_v = cell_valid[i+1];
    end
    rfq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_i        (new_entry),
      .left_i       (left_e),
      .left_valid_i (left_v),
      .left_stop_i  (left_s),
      .right_i      (right_e),
      .right_valid_i(right_v),
      .sfx_i        (sfx_vec[i]),
      .entry_o      (cell_entry[i]),
      .valid_o      (cell_valid[i]),
      .stop_o       (stop_vec[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.enq) begin
      count_d = count_q + CntW'(1);
    end else if (take_head) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    rejected_d   = xfer && (mode_i == MODE_ENQ) && full;
    head_valid_d = take_head;
    out_entry_d  = take_head ? cell_entry[0] : '0;
    occ_d        = OccW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= POLICY_FIFO;
      capacity_q  <= CapacityReset;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_POLICY:   policy_q   <= cfg_data_i[0];
          CFG_CAPACITY: capacity_q <= cfg_data_i[CapW-1:0];
          default: ;
        endcase
      end
      count_q <= count_d;
      if (xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      rejected_q   <= rejected_d;
      head_valid_q <= head_valid_d;
      out_entry_q  <= out_entry_d;
      occ_q        <= occ_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign rejected_o        = rejected_q;
  assign head_valid_o      = head_valid_q;
  assign out_request_id_o  = out_entry_q.id;
  assign out_length_sec_o  = out_entry_q.sec;
  assign out_length_nsec_o = out_entry_q.nsec;
  assign out_image_id_o    = out_entry_q.image;
  assign out_operation_o   = out_entry_q.op;
  assign out_overwrite_o   = out_entry_q.ow;
  assign occupancy_o       = occ_q;

endmodule

@@ hdl/rfq_cell.sv @@
// ----------------------------------------------------------------------------
// Request queue cell
// One queue slot: holds, shifts toward the head, shifts toward the tail or
// takes the new request.
// ----------------------------------------------------------------------------
module rfq_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rfq_pkg::ctrl_t ctrl_i,
  input  rfq_pkg::entry_t new_i,
  input  rfq_pkg::entry_t left_i,
  input  logic           left_valid_i,
  input  logic           left_stop_i,
  input  rfq_pkg::entry_t right_i,
  input  logic           right_valid_i,
  input  logic           sfx_i,
  output rfq_pkg::entry_t entry_o,
  output logic           valid_o,
  output logic           stop_o
);
  import rfq_pkg::*;

  entry_t entry_q, entry_d;
  logic   valid_q, valid_d;
  logic   not_longer;

  assign not_longer = {entry_q.sec, entry_q.nsec} <= {new_i.sec, new_i.nsec};
  assign stop_o     = valid_q && (!ctrl_i.sjn || not_longer);

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (ctrl_i.deq) begin
      entry_d = right_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.enq && !sfx_i) begin
      if (left_stop_i) begin
        entry_d = new_i;
        valid_d = 1'b1;
      end else begin
        entry_d = left_i;
        valid_d = left_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;

endmodule

@@ hdl/rfq_checker.sv @@
// ----------------------------------------------------------------------------
// Request queue checker
// Port-level properties of results, bound to the queue top level.
// ----------------------------------------------------------------------------
module rfq_checker #(
  parameter int unsigned QUEUE_DEPTH = rfq_pkg::DefaultDepth
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         rejected_o,
  input logic                         head_valid_o,
  input logic [rfq_pkg::IdW-1:0]      out_request_id_o,
  input logic [rfq_pkg::SecW-1:0]     out_length_sec_o,
  input logic [rfq_pkg::NsecW-1:0]    out_length_nsec_o,
  input logic [rfq_pkg::ImageW-1:0]   out_image_id_o,
  input logic [rfq_pkg::OpW-1:0]      out_operation_o,
  input logic                         out_overwrite_o,
  input logic [rfq_pkg::OccW-1:0]     occupancy_o
);
  import rfq_pkg::*;

  a_reject_xor_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(rejected_o && head_valid_o))
    else $error("rejected and head_valid both set");

  a_empty_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !head_valid_o) |-> (out_request_id_o == '0 &&
      out_length_sec_o == '0 && out_length_nsec_o == '0 && out_image_id_o == '0 &&
      out_operation_o == '0 && !out_overwrite_o))
    else $error("payload not zero without a dequeued entry");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((QUEUE_DEPTH > 31) || (32'(occupancy_o) <= QUEUE_DEPTH)))
    else $error("occupancy above queue depth");

  a_reject_at_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rejected_o) |-> (occupancy_o != '0))
    else $error("reject reported with empty queue");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(occupancy_o) &&
      $stable(head_valid_o)))
    else $error("stalled result changed");

endmodule

bind fifo_or_shortest_first_request_queue rfq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_rfq_checker (.*);

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// Request queue testbench
// Drives enqueue and dequeue transfers with random gaps and output stalls,
// mirrors the queue order for both policies and every capacity setting, and
// checks each result field against the mirror.
// ----------------------------------------------------------------------------
module tb;
  import rfq_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic   mode;
    entry_t e;
  } request_t;

  typedef struct packed {
    logic            rejected;
    logic            head_valid;
    entry_t          head;
    logic [OccW-1:0] occ;
  } outcome_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic                mode_i        = MODE_ENQ;
  logic [IdW-1:0]      request_id_i  = '0;
  logic [SecW-1:0]     length_sec_i  = '0;
  logic [NsecW-1:0]    length_nsec_i = '0;
  logic [ImageW-1:0]   image_id_i    = '0;
  logic [OpW-1:0]      operation_i   = '0;
  logic                overwrite_i   = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic                rejected_o;
  logic                head_valid_o;
  logic [IdW-1:0]      out_request_id_o;
  logic [SecW-1:0]     out_length_sec_o;
  logic [NsecW-1:0]    out_length_nsec_o;
  logic [ImageW-1:0]   out_image_id_o;
  logic [OpW-1:0]      out_operation_o;
  logic                out_overwrite_o;
  logic [OccW-1:0]     occupancy_o;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgW-1:0]     cfg_data_i    = '0;

  fifo_or_shortest_first_request_queue dut (.*);

  always #1 clk_i = ~clk_i;

  request_t    pending_q[$];
  entry_t      held_q[$];
  outcome_t    due_q[$];
  request_t    next_req;
  outcome_t    got;
  outcome_t    want;
  logic        cur_policy   = POLICY_FIFO;
  logic [CapW-1:0] cur_capacity = CapacityReset;
  bit          steady       = 1'b0;
  int unsigned hold_ask     = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;
  int unsigned errors       = 0;
  int unsigned cycle        = 0;

  function automatic int unsigned fit_capacity(logic [CapW-1:0] cap);
    if (cap == 0) return 1;
    if (cap > DefaultDepth) return DefaultDepth;
    return 32'(cap);
  endfunction

  // Mirror one transfer and return the result the block owes for it.
  function automatic outcome_t queue_step(request_t r);
    outcome_t o;
    int       pos;
    o = '0;
    if (r.mode == MODE_ENQ) begin
      if (held_q.size() >= fit_capacity(cur_capacity)) begin
        o.rejected = 1'b1;
      end else begin
        pos = held_q.size();
        if (cur_policy == POLICY_SJN) begin
          while (pos > 0 && {held_q[pos-1].sec, held_q[pos-1].nsec} > {r.e.sec, r.e.nsec})
            pos--;
        end
        held_q.insert(pos, r.e);
      end
    end else if (held_q.size() > 0) begin
      o.head_valid = 1'b1;
      o.head = held_q.pop_front();
    end
    o.occ = OccW'(held_q.size());
    return o;
  endfunction

  task automatic report(string what);
    errors++;
    if (errors <= 50) $display("MISMATCH cycle %0d: %s", cycle, what);
  endtask

  function automatic void offer_enq(logic [IdW-1:0] id, logic [SecW-1:0] sec,
                                    logic [NsecW-1:0] nsec, logic [ImageW-1:0] image,
                                    logic [OpW-1:0] op, logic ow);
    request_t r;
    r.mode = MODE_ENQ;
    r.e = '{id: id, sec: sec, nsec: nsec, image: image, op: op, ow: ow};
    pending_q.push_back(r);
  endfunction

  function automatic void offer_deq();
    request_t r;
    r.mode = MODE_DEQ;
    r.e = '{id: $urandom, sec: $urandom, nsec: NsecW'($urandom), image: $urandom,
            op: OpW'($urandom), ow: 1'($urandom)};
    pending_q.push_back(r);
  endfunction

  function automatic void offer_random(int unsigned enq_pct);
    logic [SecW-1:0]  sec;
    logic [NsecW-1:0] nsec;
    case ($urandom_range(3))
      0, 1:    sec = $urandom_range(3);
      2:       sec = $urandom;
      default: sec = '1;
    endcase
    case ($urandom_range(3))
      0, 1:    nsec = NsecW'($urandom_range(3));
      2:       nsec = NsecW'($urandom_range(999999999));
      default: nsec = NsecW'($urandom);
    endcase
    if ($urandom_range(99) < enq_pct)
      offer_enq($urandom, sec, nsec, $urandom, OpW'($urandom_range(15)), 1'($urandom));
    else
      offer_deq();
  endfunction

  task automatic set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_POLICY) cur_policy = val[0];
    else cur_capacity = CapW'(val);
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || due_q.size() > 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Sender: hold the payload until transfer, then advance or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_q.size() > 0 && (steady || $urandom_range(99) >= 17)) begin
        next_req = pending_q.pop_front();
        in_valid_i    <= 1'b1;
        mode_i        <= next_req.mode;
        request_id_i  <= next_req.e.id;
        length_sec_i  <= next_req.e.sec;
        length_nsec_i <= next_req.e.nsec;
        image_id_i    <= next_req.e.image;
        operation_i   <= next_req.e.op;
        overwrite_i   <= next_req.e.ow;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (hold_seen != hold_ask) begin
        hold_seen = hold_ask;
        hold_left = 400;
      end else if (!steady && hold_left == 0 && $urandom_range(499) == 0) begin
        hold_left = $urandom_range(80, 20);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 17);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{rejected: rejected_o, head_valid: head_valid_o,
                head: '{id: out_request_id_o, sec: out_length_sec_o,
                        nsec: out_length_nsec_o, image: out_image_id_o,
                        op: out_operation_o, ow: out_overwrite_o},
                occ: occupancy_o};
        if (due_q.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          want = due_q.pop_front();
          if (got.rejected !== want.rejected)
            report($sformatf("rejected %0b, want %0b", got.rejected, want.rejected));
          if (got.head_valid !== want.head_valid)
            report($sformatf("head_valid %0b, want %0b", got.head_valid, want.head_valid));
          if (got.head.id !== want.head.id)
            report($sformatf("request_id %h, want %h", got.head.id, want.head.id));
          if (got.head.sec !== want.head.sec)
            report($sformatf("length_sec %h, want %h", got.head.sec, want.head.sec));
          if (got.head.nsec !== want.head.nsec)
            report($sformatf("length_nsec %h, want %h", got.head.nsec, want.head.nsec));
          if (got.head.image !== want.head.image)
            report($sformatf("image_id %h, want %h", got.head.image, want.head.image));
          if (got.head.op !== want.head.op)
            report($sformatf("operation %h, want %h", got.head.op, want.head.op));
          if (got.head.ow !== want.head.ow)
            report($sformatf("overwrite %0b, want %0b", got.head.ow, want.head.ow));
          if (got.occ !== want.occ)
            report($sformatf("occupancy %0d, want %0d", got.occ, want.occ));
        end
      end
      if (in_valid_i && in_ready_o)
        due_q.push_back(queue_step('{mode: mode_i,
                                     e: '{id: request_id_i, sec: length_sec_i,
                                          nsec: length_nsec_i, image: image_id_i,
                                          op: operation_i, ow: overwrite_i}}));
    end
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > CycleLimit) begin
      $display("fifo_or_shortest_first_request_queue test failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty dequeue, field extremes, nanoseconds past one second.
    offer_deq();
    offer_enq('0, '0, '0, '0, '0, 1'b0);
    offer_enq('1, '1, '1, '1, '1, 1'b1);
    offer_enq(32'h5A5A_A5A5, 32'd1, 30'd999999999, 32'hA5A5_5A5A, 4'hA, 1'b1);
    repeat (4) offer_deq();
    drain();

    // Shortest first: ties keep arrival order, nanoseconds break seconds ties.
    set_reg(CFG_POLICY, CfgW'(POLICY_SJN));
    offer_enq(32'd1, 32'd5, 30'd0, 32'd11, 4'd1, 1'b0);
    offer_enq(32'd2, 32'd3, 30'd7, 32'd12, 4'd2, 1'b1);
    offer_enq(32'd3, 32'd3, 30'd7, 32'd13, 4'd3, 1'b0);
    offer_enq(32'd4, 32'd3, 30'd6, 32'd14, 4'd4, 1'b1);
    offer_enq(32'd5, 32'd0, '1, 32'd15, 4'd5, 1'b0);
    repeat (5) offer_deq();
    drain();

    // Full queue at capacity one, and capacity zero acting as one.
    set_reg(CFG_CAPACITY, CfgW'(1));
    offer_random(100);
    offer_random(100);
    offer_deq();
    drain();
    set_reg(CFG_CAPACITY, CfgW'(0));
    offer_random(100);
    offer_random(100);
    offer_deq();
    offer_deq();
    drain();

    // Capacity above the depth, fill past full in arrival order.
    set_reg(CFG_POLICY, CfgW'(POLICY_FIFO));
    set_reg(CFG_CAPACITY, CfgW'(31));
    repeat (18) offer_random(100);
    repeat (150) offer_random(55);
    drain();

    // Switch to shortest first with entries held.
    set_reg(CFG_POLICY, CfgW'(POLICY_SJN));
    repeat (150) offer_random(50);
    drain();

    // Lower capacity below the held count.
    set_reg(CFG_CAPACITY, CfgW'(16));
    repeat (20) offer_random(100);
    drain();
    set_reg(CFG_CAPACITY, CfgW'(4));
    repeat (30) offer_random(50);
    drain();

    // Long output hold-off while requests keep coming.
    set_reg(CFG_POLICY, CfgW'(POLICY_FIFO));
    set_reg(CFG_CAPACITY, CfgW'(16));
    repeat (100) offer_random(60);
    hold_ask++;
    drain();

    // Back to back, no gaps on either side.
    steady = 1'b1;
    set_reg(CFG_POLICY, CfgW'(POLICY_SJN));
    set_reg(CFG_CAPACITY, CfgW'(8));
    repeat (300) offer_random(50);
    drain();
    steady = 1'b0;

    for (int p = 0; p < 7; p++) begin
      set_reg(CFG_POLICY, CfgW'($urandom_range(1)));
      case (p)
        0: set_reg(CFG_CAPACITY, CfgW'(2));
        1: set_reg(CFG_CAPACITY, CfgW'(17));
        2: set_reg(CFG_CAPACITY, CfgW'(16));
        3: set_reg(CFG_CAPACITY, CfgW'(1));
        default: set_reg(CFG_CAPACITY, CfgW'($urandom_range(31)));
      endcase
      repeat (150) offer_random($urandom_range(70, 30));
      drain();
    end

    repeat (5) @(posedge clk_i);
    if (errors == 0) begin
      $display("fifo_or_shortest_first_request_queue test passed");
    end else begin
      $display("fifo_or_shortest_first_request_queue test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/rfq_pkg.sv
hdl/rfq_cell.sv
hdl/fifo_or_shortest_first_request_queue.sv
hdl/rfq_checker.sv
sim/tb.sv
